// ===== hw/rtl/particle_seek_arrive_step_core_macros.svh =====
// Assertion macros used by the checker file.
`ifndef PARTICLE_SEEK_ARRIVE_STEP_CORE_MACROS_SVH
`define PARTICLE_SEEK_ARRIVE_STEP_CORE_MACROS_SVH
// antecedent implies consequent in the same cycle
`define PSA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("psa check failed");
// antecedent implies consequent in the next cycle
`define PSA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("psa check failed");
`endif

// ===== hw/rtl/psa_pkg.sv =====
// Shared types and constants of the particle seek/arrive step core.
`default_nettype none
package psa_pkg;
    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_SEEK = 2'd1;
    localparam logic [1:0] CMD_HOME = 2'd2;
    localparam logic [1:0] CFG_SEEK_SPEED = 2'd0;
    localparam logic [1:0] CFG_HOME_SPEED = 2'd1;
    localparam logic [1:0] CFG_SEEK_FORCE = 2'd2;
    localparam logic [1:0] CFG_HOME_FORCE = 2'd3;
    localparam logic [40:0] ARRIVE_RADIUS = 41'd3276800;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_DIV,
        OP_SQRT
    } iu_op_t;

    typedef struct packed {
        logic   start;
        iu_op_t op;
    } iu_req_t;
endpackage
`default_nettype wire

// ===== hw/rtl/particle_seek_arrive_step_core.sv =====
// Path, request accept to result valid: a load or unused command goes straight to the output stage;
// seek, home snap and home step run magnitude passes, each with a pre-shift of the magnitude as needed,
// on the multiply, square root and divide of the shared unit.
// Throughput: one item at a time; a new item is taken once the previous one is
// handed to the output register, which may still be waiting to be taken.
// Reset: asynchronous active low; position, velocity, home cleared, limits to defaults.
`default_nettype none
module particle_seek_arrive_step_core
    import psa_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         cmd,
    input  logic signed [31:0] vec_x,
    input  logic signed [31:0] vec_y,
    input  logic signed [31:0] vec_z,
    input  logic signed [25:0] jitter_x,
    input  logic signed [25:0] jitter_y,
    input  logic signed [25:0] jitter_z,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] pos_x,
    output logic signed [31:0] pos_y,
    output logic signed [31:0] pos_z,
    output logic               snapped,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [23:0]        cfg_data
);
    typedef enum logic [3:0] {
        S_IDLE, S_MAG_ABS, S_MAG_SHIFT, S_SQ_GO, S_SQ_WAIT, S_RT_GO, S_RT_WAIT,
        S_LEN_CHK, S_SC_MUL_GO, S_SC_MUL_WAIT, S_SC_DIV_GO, S_SC_DIV_WAIT,
        S_AFTER, S_POS_WR, S_DONE
    } state_t;

    typedef enum logic [1:0] {
        J_SEEK, J_DIST, J_HOME, J_VEL
    } job_t;

    state_t state_reg;
    job_t   job_reg;
    logic [1:0]  idx_reg;
    logic [3:0]  s_reg;
    logic [39:0] a_reg [3];
    logic [63:0] sum_reg;
    logic [40:0] len_reg;
    logic [23:0] lim_reg;
    logic [23:0] spd_reg;
    logic        snap_reg;
    logic signed [31:0] pos_reg  [3];
    logic signed [31:0] vel_reg  [3];
    logic signed [31:0] home_reg [3];
    logic signed [39:0] v_reg    [3];
    logic [23:0] seek_speed_reg, home_speed_reg, seek_force_reg, home_force_reg;
    logic        out_valid_reg;
    logic signed [31:0] out_pos_reg [3];
    logic        out_snap_reg;

    iu_req_t     iu_req;
    logic [63:0] iu_opa;
    logic [42:0] iu_opb;
    logic        iu_done;
    logic [63:0] iu_result;

    logic signed [31:0] vec_in [3];
    logic signed [25:0] jit_in [3];
    logic [39:0] v_abs;
    logic        any_big;

    function automatic logic [39:0] abs40(input logic signed [39:0] v);
        return v[39] ? 40'(-v) : 40'(v);
    endfunction

    function automatic logic signed [39:0] ext32(input logic signed [31:0] v);
        return {{8{v[31]}}, v};
    endfunction

    function automatic logic signed [31:0] sat40(input logic signed [39:0] v);
        logic signed [31:0] r;
        if (!v[39] && v[38:31] != 8'h00)
            r = 32'sh7FFF_FFFF;
        else if (v[39] && v[38:31] != 8'hFF)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [31:0] add_sat(input logic signed [31:0] p,
                                                   input logic signed [31:0] q);
        logic [32:0] s;
        logic signed [31:0] r;
        s = {p[31], p} + {q[31], q};
        if (s[32] != s[31])
            r = s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        else
            r = s[31:0];
        return r;
    endfunction

    assign vec_in[0] = vec_x;
    assign vec_in[1] = vec_y;
    assign vec_in[2] = vec_z;
    assign jit_in[0] = jitter_x;
    assign jit_in[1] = jitter_y;
    assign jit_in[2] = jitter_z;

    assign v_abs   = abs40(v_reg[idx_reg]);
    assign any_big = (a_reg[0][39:31] != 9'd0) || (a_reg[1][39:31] != 9'd0)
                  || (a_reg[2][39:31] != 9'd0);

    always_comb
    begin
        iu_req.start = 1'b0;
        iu_req.op    = OP_MUL;
        iu_opa       = '0;
        iu_opb       = '0;
        case (state_reg)
            S_SQ_GO:
            begin
                iu_req.start = 1'b1;
                iu_opa       = {24'd0, a_reg[idx_reg]};
                iu_opb       = {11'd0, a_reg[idx_reg][31:0]};
            end
            S_RT_GO:
            begin
                iu_req.start = 1'b1;
                iu_req.op    = OP_SQRT;
                iu_opa       = sum_reg;
            end
            S_SC_MUL_GO:
            begin
                iu_req.start = 1'b1;
                iu_opa       = {24'd0, v_abs};
                iu_opb       = {19'd0, lim_reg};
            end
            S_SC_DIV_GO:
            begin
                iu_req.start = 1'b1;
                iu_req.op    = OP_DIV;
                iu_opa       = sum_reg;
                iu_opb       = {2'b00, len_reg};
            end
            default:
            begin
                iu_req.start = 1'b0;
            end
        endcase
    end

    psa_iter_unit u_iter (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (iu_req),
        .opa    (iu_opa),
        .opb    (iu_opb),
        .done   (iu_done),
        .result (iu_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            job_reg        <= J_SEEK;
            idx_reg        <= '0;
            out_valid_reg  <= 1'b0;
            seek_speed_reg <= 24'd1048576;
            home_speed_reg <= 24'd1048576;
            seek_force_reg <= 24'd45875;
            home_force_reg <= 24'd19661;
            for (int i = 0; i < 3; i++)
            begin
                pos_reg[i]  <= '0;
                vel_reg[i]  <= '0;
                home_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_SEEK_SPEED: seek_speed_reg <= cfg_data;
                    CFG_HOME_SPEED: home_speed_reg <= cfg_data;
                    CFG_SEEK_FORCE: seek_force_reg <= cfg_data;
                    CFG_HOME_FORCE: home_force_reg <= cfg_data;
                    default:        seek_speed_reg <= seek_speed_reg;
                endcase
            end
            // S_DONE reloads the output register itself
            if (out_valid_reg && out_ready && state_reg != S_DONE)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        snap_reg <= 1'b0;
                        case (cmd)
                            CMD_LOAD:
                            begin
                                for (int i = 0; i < 3; i++)
                                begin
                                    pos_reg[i]  <= vec_in[i];
                                    home_reg[i] <= vec_in[i];
                                    vel_reg[i]  <= '0;
                                end
                                state_reg <= S_DONE;
                            end
                            CMD_SEEK:
                            begin
                                for (int i = 0; i < 3; i++)
                                begin
                                    v_reg[i] <= ext32(vec_in[i])
                                              + {{14{jit_in[i][25]}}, jit_in[i]}
                                              - ext32(pos_reg[i]);
                                end
                                job_reg   <= J_SEEK;
                                lim_reg   <= seek_force_reg;
                                spd_reg   <= seek_speed_reg;
                                state_reg <= S_MAG_ABS;
                            end
                            CMD_HOME:
                            begin
                                for (int i = 0; i < 3; i++)
                                begin
                                    v_reg[i] <= ext32(home_reg[i]) - ext32(pos_reg[i]);
                                end
                                job_reg   <= J_DIST;
                                lim_reg   <= home_speed_reg;
                                spd_reg   <= home_speed_reg;
                                state_reg <= S_MAG_ABS;
                            end
                            default:
                            begin
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                end
                S_MAG_ABS:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        a_reg[i] <= abs40(v_reg[i]);
                    end
                    s_reg     <= '0;
                    sum_reg   <= '0;
                    idx_reg   <= '0;
                    state_reg <= S_MAG_SHIFT;
                end
                S_MAG_SHIFT:
                begin
                    // bring every component below 2^31 before squaring
                    if (any_big)
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            a_reg[i] <= {1'b0, a_reg[i][39:1]};
                        end
                        s_reg <= s_reg + 4'd1;
                    end
                    else
                    begin
                        state_reg <= S_SQ_GO;
                    end
                end
                S_SQ_GO:
                begin
                    state_reg <= S_SQ_WAIT;
                end
                S_SQ_WAIT:
                begin
                    if (iu_done)
                    begin
                        sum_reg <= sum_reg + iu_result;
                        if (idx_reg == 2'd2)
                        begin
                            idx_reg   <= '0;
                            state_reg <= S_RT_GO;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + 2'd1;
                            state_reg <= S_SQ_GO;
                        end
                    end
                end
                S_RT_GO:
                begin
                    state_reg <= S_RT_WAIT;
                end
                S_RT_WAIT:
                begin
                    if (iu_done)
                    begin
                        len_reg   <= {9'd0, iu_result[31:0]} << s_reg;
                        state_reg <= S_LEN_CHK;
                    end
                end
                S_LEN_CHK:
                begin
                    idx_reg <= '0;
                    if (job_reg == J_DIST)
                    begin
                        if (len_reg > ARRIVE_RADIUS)
                        begin
                            state_reg <= S_SC_MUL_GO;
                        end
                        else
                        begin
                            for (int i = 0; i < 3; i++)
                            begin
                                pos_reg[i] <= home_reg[i];
                                vel_reg[i] <= '0;
                            end
                            snap_reg  <= 1'b1;
                            state_reg <= S_DONE;
                        end
                    end
                    else if (len_reg > {17'd0, lim_reg})
                    begin
                        state_reg <= S_SC_MUL_GO;
                    end
                    else
                    begin
                        state_reg <= S_AFTER;
                    end
                end
                S_SC_MUL_GO:
                begin
                    state_reg <= S_SC_MUL_WAIT;
                end
                S_SC_MUL_WAIT:
                begin
                    if (iu_done)
                    begin
                        sum_reg   <= iu_result;
                        state_reg <= S_SC_DIV_GO;
                    end
                end
                S_SC_DIV_GO:
                begin
                    state_reg <= S_SC_DIV_WAIT;
                end
                S_SC_DIV_WAIT:
                begin
                    if (iu_done)
                    begin
                        v_reg[idx_reg] <= v_reg[idx_reg][39] ? -$signed(iu_result[39:0])
                                                             : $signed(iu_result[39:0]);
                        if (idx_reg == 2'd2)
                        begin
                            state_reg <= S_AFTER;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + 2'd1;
                            state_reg <= S_SC_MUL_GO;
                        end
                    end
                end
                S_AFTER:
                begin
                    case (job_reg)
                        J_SEEK:
                        begin
                            for (int i = 0; i < 3; i++)
                            begin
                                v_reg[i] <= ext32(vel_reg[i]) + v_reg[i];
                            end
                            job_reg   <= J_VEL;
                            lim_reg   <= spd_reg;
                            state_reg <= S_MAG_ABS;
                        end
                        J_DIST:
                        begin
                            for (int i = 0; i < 3; i++)
                            begin
                                v_reg[i] <= v_reg[i] - ext32(vel_reg[i]);
                            end
                            job_reg   <= J_HOME;
                            lim_reg   <= home_force_reg;
                            state_reg <= S_MAG_ABS;
                        end
                        J_HOME:
                        begin
                            // gain of five as 4v + v
                            for (int i = 0; i < 3; i++)
                            begin
                                v_reg[i] <= ext32(vel_reg[i]) + (v_reg[i] <<< 2) + v_reg[i];
                            end
                            job_reg   <= J_VEL;
                            lim_reg   <= spd_reg;
                            state_reg <= S_MAG_ABS;
                        end
                        default:
                        begin
                            for (int i = 0; i < 3; i++)
                            begin
                                vel_reg[i] <= sat40(v_reg[i]);
                            end
                            state_reg <= S_POS_WR;
                        end
                    endcase
                end
                S_POS_WR:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        pos_reg[i] <= add_sat(pos_reg[i], vel_reg[i]);
                    end
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            out_pos_reg[i] <= pos_reg[i];
                        end
                        out_snap_reg  <= snap_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign pos_x     = out_pos_reg[0];
    assign pos_y     = out_pos_reg[1];
    assign pos_z     = out_pos_reg[2];
    assign snapped   = out_snap_reg;
endmodule
`default_nettype wire

// ===== hw/rtl/psa_iter_unit.sv =====
// Shared iterative unit: shift-add multiply, restoring divide, integer square root.
`default_nettype none
module psa_iter_unit
    import psa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  iu_req_t     req,
    input  logic [63:0] opa,
    input  logic [42:0] opb,
    output logic        done,
    output logic [63:0] result
);
    iu_op_t      op_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [6:0]  cnt_reg;
    logic [63:0] acc_reg;
    logic [63:0] mc_reg;
    logic [31:0] mp_reg;
    logic [42:0] rem_reg;
    logic [42:0] den_reg;
    logic [63:0] x_reg;
    logic [63:0] r_reg;
    logic [63:0] bit_reg;

    logic [42:0] rem_sh;
    logic [63:0] rb;

    assign rem_sh = {rem_reg[41:0], acc_reg[63]};
    assign rb     = r_reg + bit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg   <= OP_MUL;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                op_reg   <= req.op;
                busy_reg <= 1'b1;
                cnt_reg  <= (req.op == OP_DIV) ? 7'd63 : 7'd31;
                acc_reg  <= (req.op == OP_DIV) ? opa : 64'd0;
                mc_reg   <= opa;
                mp_reg   <= opb[31:0];
                rem_reg  <= '0;
                den_reg  <= opb;
                x_reg    <= opa;
                r_reg    <= '0;
                bit_reg  <= 64'h4000_0000_0000_0000;
            end
            else if (busy_reg)
            begin
                case (op_reg)
                    OP_MUL:
                    begin
                        if (mp_reg[0])
                        begin
                            acc_reg <= acc_reg + mc_reg;
                        end
                        mc_reg <= {mc_reg[62:0], 1'b0};
                        mp_reg <= {1'b0, mp_reg[31:1]};
                    end
                    OP_DIV:
                    begin
                        if (rem_sh >= den_reg)
                        begin
                            rem_reg <= rem_sh - den_reg;
                            acc_reg <= {acc_reg[62:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg <= rem_sh;
                            acc_reg <= {acc_reg[62:0], 1'b0};
                        end
                    end
                    OP_SQRT:
                    begin
                        if (x_reg >= rb)
                        begin
                            x_reg <= x_reg - rb;
                            r_reg <= {1'b0, r_reg[63:1]} + bit_reg;
                        end
                        else
                        begin
                            r_reg <= {1'b0, r_reg[63:1]};
                        end
                        bit_reg <= {2'b00, bit_reg[63:2]};
                    end
                    default:
                    begin
                        acc_reg <= acc_reg;
                    end
                endcase
                if (cnt_reg == 7'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 7'd1;
                end
            end
        end
    end

    assign done   = done_reg;
    assign result = (op_reg == OP_SQRT) ? r_reg : acc_reg;
endmodule
`default_nettype wire

// ===== hw/rtl/psa_checker.sv =====
// Port-level checks for the particle seek/arrive step core, with its bind.
`default_nettype none
`include "particle_seek_arrive_step_core_macros.svh"
module psa_checker (
    input wire               clk,
    input wire               rst_n,
    input wire               in_valid,
    input wire               in_ready,
    input wire               out_valid,
    input wire               out_ready,
    input wire signed [31:0] pos_x,
    input wire signed [31:0] pos_y,
    input wire signed [31:0] pos_z,
    input wire               snapped
);
    // an accepted request drops in_ready in the next cycle
    `PSA_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
    // a new result only appears when a request was in progress
    `PSA_ASSERT_IMP(a_result_from_work, $rose(out_valid), !$past(in_ready))
    `PSA_ASSERT_NXT(a_out_holds, out_valid && !out_ready, out_valid)
    `PSA_ASSERT_NXT(a_out_stable, out_valid && !out_ready,
        $stable(pos_x) && $stable(pos_y) && $stable(pos_z) && $stable(snapped))
endmodule

bind particle_seek_arrive_step_core psa_checker u_psa_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .pos_z     (pos_z),
    .snapped   (snapped)
);
`default_nettype wire
